@@ rtl/core/source_char_tokenizer_macros.svh @@
// assertion macros shared by the tokenizer modules
// every macro samples on clk and is disabled while rst_n is low
`ifndef SOURCE_CHAR_TOKENIZER_MACROS_SVH
`define SOURCE_CHAR_TOKENIZER_MACROS_SVH

// condition in this cycle implies consequence in the same cycle
`define SCT_ASSERT_NOW(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// condition in this cycle implies consequence in the next cycle
`define SCT_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

@@ rtl/core/sct_pkg.sv @@
// types, codes and byte classes for the source character tokenizer
// no dependencies
package sct_pkg;

    // token kinds on the result side
    typedef enum logic [2:0] {
        KIND_NAME = 3'd0,
        KIND_NUM  = 3'd1,
        KIND_STR  = 3'd2,
        KIND_OP   = 3'd3,
        KIND_ERR  = 3'd4,
        KIND_END  = 3'd5
    } sct_kind_t;

    // lexer modes between bytes
    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_NAME    = 3'd1,
        MODE_NUM     = 3'd2,
        MODE_STR     = 3'd3,
        MODE_OP2     = 3'd4,
        MODE_COMMENT = 3'd5
    } sct_mode_t;

    // front sequencing: normal run, final byte, end marker
    typedef enum logic [1:0] {
        PH_RUN  = 2'd0,
        PH_LAST = 2'd1,
        PH_MARK = 2'd2
    } sct_phase_t;

    typedef struct packed {
        logic [7:0] char_in;
        logic       source_end;
    } sct_in_t;

    typedef struct packed {
        logic [7:0] char_out;
        sct_kind_t  kind;
        logic       token_first;
        logic       token_last;
        logic       is_keyword;
    } sct_out_t;

    // write request from front to result queue
    typedef struct packed {
        logic     valid;
        sct_out_t data;
    } sct_qwr_t;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_STAR   = 8'h2A;

    localparam logic [3:0] NAME_LEN_MAX = 4'd15;
    localparam logic [3:0] KW_LONG_LEN  = 4'd7;
    localparam logic [3:0] KW_SHORT_LEN = 4'd2;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
               c == CH_UNDER || c == CH_DOLLAR;
    endfunction

    function automatic logic is_numch(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || c == CH_DOT;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || c == CH_LF || c == CH_CR || c == CH_TAB;
    endfunction

    // < % > = + - * / ^ ~ ! ( ) [ ] { } ; ,
    function automatic logic is_single_op(input logic [7:0] c);
        logic hit;
        case (c) inside
            8'h3C, 8'h25, 8'h3E, 8'h3D, 8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h5E, 8'h7E,
            8'h21, 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h3B, 8'h2C:
                hit = 1'b1;
            default:
                hit = 1'b0;
        endcase
        return hit;
    endfunction

    // >= <= == != **
    function automatic logic is_pair(input logic [7:0] a, input logic [7:0] b);
        if (b == CH_EQ)
            return a == CH_GT || a == CH_LT || a == CH_EQ || a == CH_BANG;
        return a == CH_STAR && b == CH_STAR;
    endfunction

    // letters of the long keyword by position
    function automatic logic [7:0] kw_long_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = "e";
            3'd1:    c = "x";
            3'd2:    c = "h";
            3'd3:    c = "a";
            3'd4:    c = "u";
            3'd5:    c = "s";
            3'd6:    c = "t";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/core/source_char_tokenizer.sv @@
// source character tokenizer: labels each source byte with token kind and flags
// a byte's result is written to the queue at the edge that accepts the next byte and reaches the
// result port once earlier results are popped; one byte per cycle while the queue is not full
// a final byte holds full high while its own result and then the end marker are written
// a full result queue holds full high; rst_n clears lexer state and queue asynchronously
// depends on sct_pkg, sct_front and sct_result_queue

module source_char_tokenizer
    import sct_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  sct_in_t  item,
    output logic     full,
    output logic     empty,
    input  logic     pop,
    output sct_out_t token
);

    sct_qwr_t qwr;
    logic     q_full;

    // classifier with one byte of lookahead
    sct_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .item   (item),
        .q_full (q_full),
        .full   (full),
        .qwr    (qwr)
    );

    // result queue toward the consumer
    sct_result_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .qwr    (qwr),
        .pop    (pop),
        .q_full (q_full),
        .empty  (empty),
        .token  (token)
    );

endmodule

@@ rtl/core/sct_front.sv @@
// front end: holds one byte of lookahead, classifies it and tracks lexer state
// depends on sct_pkg and source_char_tokenizer_macros.svh
`include "source_char_tokenizer_macros.svh"

module sct_front
    import sct_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  sct_in_t  item,
    input  logic     q_full,
    output logic     full,
    output sct_qwr_t qwr
);

    sct_phase_t phase_reg, phase_next;
    logic [7:0] held_byte_reg, held_byte_next;
    logic       held_valid_reg, held_valid_next;
    sct_mode_t  mode_reg, mode_next;
    logic [7:0] psb_reg, psb_next;
    logic [2:0] km_reg, km_next;
    logic [3:0] nl_reg, nl_next;
    logic       err_reg, err_next;

    logic       step;
    logic       active;
    logic       has_next;
    logic [7:0] nx;

    // lexer results for the held byte
    logic       p_emit;
    sct_out_t   p_out;
    sct_mode_t  p_mode;
    logic [7:0] p_psb;
    logic [2:0] p_km;
    logic [3:0] p_nl;
    logic       p_err;

    // name tracking helpers
    logic       in_name;
    logic       first;
    logic       more;
    logic [2:0] km_base;
    logic [3:0] nl_base;
    logic [2:0] km_upd;
    logic [3:0] nl_upd;
    logic       str_close;
    logic [7:0] b;

    assign b = held_byte_reg;

    // phase next state
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_RUN:
            begin
                if (step && item.source_end)
                    phase_next = PH_LAST;
            end
            PH_LAST:
            begin
                if (step)
                    phase_next = PH_MARK;
            end
            PH_MARK:
            begin
                if (step)
                    phase_next = PH_RUN;
            end
            default:
                phase_next = PH_RUN;
        endcase
    end

    // phase outputs: when to work and which lookahead applies
    always_comb
    begin
        full     = 1'b1;
        step     = 1'b0;
        active   = 1'b0;
        has_next = 1'b0;
        nx       = item.char_in;
        unique case (phase_reg)
            PH_RUN:
            begin
                full     = q_full;
                step     = push && !q_full;
                active   = held_valid_reg;
                has_next = 1'b1;
            end
            PH_LAST:
            begin
                step   = !q_full;
                active = held_valid_reg;
            end
            PH_MARK:
            begin
                step = !q_full;
            end
            default:
            begin
                full = 1'b1;
            end
        endcase
    end

    // keyword tracking for a name byte
    always_comb
    begin
        first   = (mode_reg == MODE_IDLE);
        km_base = first ? 3'b111 : km_reg;
        nl_base = first ? 4'd0 : nl_reg;
        km_upd  = km_base;
        if (nl_base >= KW_LONG_LEN || kw_long_char(nl_base[2:0]) != b)
            km_upd[0] = 1'b0;
        if (nl_base >= KW_SHORT_LEN || (nl_base[0] ? 8'("o") : 8'("d")) != b)
            km_upd[1] = 1'b0;
        if (nl_base >= KW_SHORT_LEN || (nl_base[0] ? 8'("f") : 8'("i")) != b)
            km_upd[2] = 1'b0;
        nl_upd = (nl_base == NAME_LEN_MAX) ? NAME_LEN_MAX : nl_base + 4'd1;
    end

    // classify the held byte against the lookahead byte
    always_comb
    begin
        p_emit    = 1'b0;
        p_out     = '{char_out: b, kind: KIND_OP, token_first: 1'b0,
                      token_last: 1'b0, is_keyword: 1'b0};
        p_mode    = mode_reg;
        p_psb     = psb_reg;
        p_km      = km_reg;
        p_nl      = nl_reg;
        p_err     = err_reg;
        in_name   = mode_reg == MODE_NAME || (mode_reg == MODE_IDLE && is_letter(b));
        more      = 1'b0;
        str_close = b == CH_QUOTE && psb_reg != CH_BSLASH;
        if (active && !err_reg)
        begin
            case (mode_reg)
                MODE_STR:
                begin
                    p_emit           = 1'b1;
                    p_out.kind       = KIND_STR;
                    p_out.token_last = str_close || !has_next;
                    p_mode           = str_close ? MODE_IDLE : MODE_STR;
                    p_psb            = b;
                end
                MODE_OP2:
                begin
                    p_emit           = 1'b1;
                    p_out.kind       = KIND_OP;
                    p_out.token_last = 1'b1;
                    p_mode           = MODE_IDLE;
                end
                MODE_COMMENT:
                begin
                    if (b == CH_LF || b == CH_CR)
                        p_mode = MODE_IDLE;
                end
                default:
                begin
                    if (in_name)
                    begin
                        more              = has_next && is_letter(nx);
                        p_km              = km_upd;
                        p_nl              = nl_upd;
                        p_emit            = 1'b1;
                        p_out.kind        = KIND_NAME;
                        p_out.token_first = first;
                        p_out.token_last  = !more;
                        p_out.is_keyword  = !more &&
                            ((km_upd[0] && nl_upd == KW_LONG_LEN) ||
                             ((km_upd[1] || km_upd[2]) && nl_upd == KW_SHORT_LEN));
                        p_mode            = more ? MODE_NAME : MODE_IDLE;
                    end
                    else if (mode_reg == MODE_NUM || is_numch(b))
                    begin
                        more              = has_next && is_numch(nx);
                        p_emit            = 1'b1;
                        p_out.kind        = KIND_NUM;
                        p_out.token_first = first;
                        p_out.token_last  = !more;
                        p_mode            = more ? MODE_NUM : MODE_IDLE;
                    end
                    else if (b == CH_QUOTE)
                    begin
                        p_emit            = 1'b1;
                        p_out.kind        = KIND_STR;
                        p_out.token_first = 1'b1;
                        p_out.token_last  = !has_next;
                        p_psb             = b;
                        p_mode            = MODE_STR;
                    end
                    else if (is_space(b))
                    begin
                        p_mode = MODE_IDLE;
                    end
                    else if (b == CH_SLASH && has_next && nx == CH_SLASH)
                    begin
                        p_mode = MODE_COMMENT;
                    end
                    else if (has_next && is_pair(b, nx))
                    begin
                        p_emit            = 1'b1;
                        p_out.kind        = KIND_OP;
                        p_out.token_first = 1'b1;
                        p_mode            = MODE_OP2;
                    end
                    else if (is_single_op(b))
                    begin
                        p_emit            = 1'b1;
                        p_out.kind        = KIND_OP;
                        p_out.token_first = 1'b1;
                        p_out.token_last  = 1'b1;
                        p_mode            = MODE_IDLE;
                    end
                    else
                    begin
                        p_emit            = 1'b1;
                        p_out.kind        = KIND_ERR;
                        p_out.token_first = 1'b1;
                        p_out.token_last  = 1'b1;
                        p_err             = 1'b1;
                        p_mode            = MODE_IDLE;
                    end
                end
            endcase
        end
    end

    // state update and queue write request
    always_comb
    begin
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        mode_next       = mode_reg;
        psb_next        = psb_reg;
        km_next         = km_reg;
        nl_next         = nl_reg;
        err_next        = err_reg;
        qwr.valid       = 1'b0;
        qwr.data        = p_out;
        if (step)
        begin
            if (phase_reg == PH_MARK)
            begin
                qwr.valid       = 1'b1;
                qwr.data        = '{char_out: 8'h00, kind: KIND_END, token_first: 1'b1,
                                    token_last: 1'b1, is_keyword: 1'b0};
                held_byte_next  = 8'h00;
                held_valid_next = 1'b0;
                mode_next       = MODE_IDLE;
                psb_next        = 8'h00;
                km_next         = 3'b111;
                nl_next         = 4'd0;
                err_next        = 1'b0;
            end
            else
            begin
                qwr.valid = p_emit;
                mode_next = p_mode;
                psb_next  = p_psb;
                km_next   = p_km;
                nl_next   = p_nl;
                err_next  = p_err;
                if (phase_reg == PH_RUN)
                begin
                    held_byte_next  = item.char_in;
                    held_valid_next = 1'b1;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_RUN;
            held_byte_reg  <= 8'h00;
            held_valid_reg <= 1'b0;
            mode_reg       <= MODE_IDLE;
            psb_reg        <= 8'h00;
            km_reg         <= 3'b111;
            nl_reg         <= 4'd0;
            err_reg        <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            mode_reg       <= mode_next;
            psb_reg        <= psb_next;
            km_reg         <= km_next;
            nl_reg         <= nl_next;
            err_reg        <= err_next;
        end
    end

    `SCT_ASSERT_NEXT(a_last_then_mark, step && phase_reg == PH_LAST, phase_reg == PH_MARK, "final byte not followed by end marker")
    `SCT_ASSERT_NEXT(a_mark_resets, step && phase_reg == PH_MARK, !held_valid_reg && !err_reg && mode_reg == MODE_IDLE, "state not cleared after end marker")
    `SCT_ASSERT_NOW(a_quiet_after_error, err_reg && phase_reg != PH_MARK, !qwr.valid, "request issued after an error")

endmodule

@@ rtl/core/sct_result_queue.sv @@
// back end: short result queue between the classifier and the result port
// depends on sct_pkg and source_char_tokenizer_macros.svh
`include "source_char_tokenizer_macros.svh"

module sct_result_queue
    import sct_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  sct_qwr_t qwr,
    input  logic     pop,
    output logic     q_full,
    output logic     empty,
    output sct_out_t token
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_MAX   = CW'(DEPTH);

    sct_out_t      buf_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          wr_en;
    logic          rd_en;

    assign q_full = (cnt_reg == CNT_MAX);
    assign empty  = (cnt_reg == '0);
    assign wr_en  = qwr.valid && !q_full;
    assign rd_en  = pop && !empty;
    assign token  = buf_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        if (wr_en && !rd_en)
            cnt_next = cnt_reg + 1'b1;
        else if (rd_en && !wr_en)
            cnt_next = cnt_reg - 1'b1;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // result storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            buf_reg[wr_ptr_reg] <= qwr.data;
    end

    `SCT_ASSERT_NOW(a_no_drop, qwr.valid, !q_full, "result request while queue full")
    `SCT_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= CNT_MAX, "fill count beyond depth")
    `SCT_ASSERT_NEXT(a_cnt_grow, wr_en && !rd_en, cnt_reg == $past(cnt_reg) + 1'b1, "fill count did not grow on write")

endmodule

@@ bench/source_char_tokenizer_tb.sv @@
// testbench for source_char_tokenizer: directed and random source text, token-by-token check
// needs sct_pkg and the tokenizer rtl; predicts every token and compares in order
// queue handshake on both sides with random gaps

module source_char_tokenizer_tb
    import sct_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     push = 1'b0;
    sct_in_t  item = '0;
    logic     full;
    logic     empty;
    logic     pop = 1'b0;
    sct_out_t token;

    source_char_tokenizer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .item  (item),
        .full  (full),
        .empty (empty),
        .pop   (pop),
        .token (token)
    );

    // requests still to be sent and tokens still to come
    sct_in_t    pending_items[$];
    sct_out_t   expected_tokens[$];
    logic [7:0] src_buf[$];
    int         error_count = 0;

    string operator_chars = "<%>=+-*/^~!()[]{};,";
    string pair_words[5]  = '{">=", "<=", "==", "!=", "**"};
    string kw_words[3]    = '{"exhaust", "do", "if"};
    string near_words[8]  = '{"exhaus", "exhaustx", "d", "dox", "i", "iff", "Do", "fi"};

    // lexer state mirrored from the block
    logic [7:0] hold_byte;
    logic       hold_valid;
    sct_mode_t  mode;
    logic [7:0] str_prev;
    logic [2:0] kw_hits;
    logic [3:0] name_len;
    logic       err_seen;

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // byte classes
    function automatic bit name_char(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_" || c == "$";
    endfunction

    function automatic bit number_char(logic [7:0] c);
        return (c >= "0" && c <= "9") || c == ".";
    endfunction

    function automatic bit blank_char(logic [7:0] c);
        return c == " " || c == "\n" || c == "\r" || c == "\t";
    endfunction

    function automatic bit single_operator(logic [7:0] c);
        for (int i = 0; i < operator_chars.len(); i++)
            if (operator_chars[i] == c)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit forms_pair(logic [7:0] a, logic [7:0] b);
        if (b == "=")
            return a == ">" || a == "<" || a == "=" || a == "!";
        return a == "*" && b == "*";
    endfunction

    function automatic bit spells_at(string w, logic [3:0] pos, logic [7:0] b);
        return pos < w.len() && w[pos] == b;
    endfunction

    function automatic void clear_lexer();
        hold_byte  = 8'h00;
        hold_valid = 1'b0;
        mode       = MODE_IDLE;
        str_prev   = 8'h00;
        kw_hits    = 3'b111;
        name_len   = 4'd0;
        err_seen   = 1'b0;
    endfunction

    function automatic void expect_token(logic [7:0] ch, sct_kind_t k, logic first,
                                         logic last, logic kw);
        sct_out_t t;
        t.char_out    = ch;
        t.kind        = k;
        t.token_first = first;
        t.token_last  = last;
        t.is_keyword  = kw;
        expected_tokens = {expected_tokens, t};
    endfunction

    // labels one byte, given the byte after it when there is one
    function automatic void label_byte(logic [7:0] b, bit has_next, logic [7:0] nx);
        bit more;
        bit first;
        bit hit;
        if (err_seen)
            return;
        case (mode)
            MODE_NAME, MODE_NUM: ;
            MODE_STR:
            begin
                if (b == "\"" && str_prev != "\\")
                begin
                    expect_token(b, KIND_STR, 1'b0, 1'b1, 1'b0);
                    mode = MODE_IDLE;
                end
                else
                begin
                    expect_token(b, KIND_STR, 1'b0, !has_next, 1'b0);
                end
                str_prev = b;
                return;
            end
            MODE_OP2:
            begin
                expect_token(b, KIND_OP, 1'b0, 1'b1, 1'b0);
                mode = MODE_IDLE;
                return;
            end
            MODE_COMMENT:
            begin
                if (b == "\n" || b == "\r")
                    mode = MODE_IDLE;
                return;
            end
            default: mode = MODE_IDLE;
        endcase

        // names with keyword tracking
        if (mode == MODE_NAME || (mode == MODE_IDLE && name_char(b)))
        begin
            first = (mode == MODE_IDLE);
            if (first)
            begin
                kw_hits  = 3'b111;
                name_len = 4'd0;
            end
            if (!spells_at("exhaust", name_len, b))
                kw_hits[0] = 1'b0;
            if (!spells_at("do", name_len, b))
                kw_hits[1] = 1'b0;
            if (!spells_at("if", name_len, b))
                kw_hits[2] = 1'b0;
            if (name_len != 4'd15)
                name_len = name_len + 4'd1;
            more = has_next && name_char(nx);
            hit  = (kw_hits[0] && name_len == 4'd7) || (|kw_hits[2:1] && name_len == 4'd2);
            expect_token(b, KIND_NAME, first, !more, !more && hit);
            mode = more ? MODE_NAME : MODE_IDLE;
            return;
        end

        // numbers
        if (mode == MODE_NUM || number_char(b))
        begin
            first = (mode == MODE_IDLE);
            more  = has_next && number_char(nx);
            expect_token(b, KIND_NUM, first, !more, 1'b0);
            mode = more ? MODE_NUM : MODE_IDLE;
            return;
        end

        // string opener, whitespace, comment opener, operators, unknown
        if (b == "\"")
        begin
            expect_token(b, KIND_STR, 1'b1, !has_next, 1'b0);
            str_prev = b;
            mode     = MODE_STR;
        end
        else if (blank_char(b))
            ;
        else if (b == "/" && has_next && nx == "/")
            mode = MODE_COMMENT;
        else if (has_next && forms_pair(b, nx))
        begin
            expect_token(b, KIND_OP, 1'b1, 1'b0, 1'b0);
            mode = MODE_OP2;
        end
        else if (single_operator(b))
            expect_token(b, KIND_OP, 1'b1, 1'b1, 1'b0);
        else
        begin
            expect_token(b, KIND_ERR, 1'b1, 1'b1, 1'b0);
            err_seen = 1'b1;
        end
    endfunction

    // one accepted request: the held byte is labeled now that its follower is known
    function automatic void take_char(logic [7:0] c, logic last_byte);
        if (hold_valid)
            label_byte(hold_byte, 1'b1, c);
        if (last_byte)
        begin
            label_byte(c, 1'b0, 8'h00);
            expect_token(8'h00, KIND_END, 1'b1, 1'b1, 1'b0);
            clear_lexer();
        end
        else
        begin
            hold_byte  = c;
            hold_valid = 1'b1;
        end
    endfunction

    // gap length: mostly none or short, a few long, sometimes a quiet stretch
    function automatic int pick_gap(inout int quiet);
        int r;
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            quiet = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    task automatic report_mismatch(string msg);
        error_count++;
        if (error_count <= 100)
            $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    task automatic check_token(sct_out_t got);
        sct_out_t want;
        if (expected_tokens.size() == 0)
        begin
            report_mismatch($sformatf("token %h with nothing expected", got));
            return;
        end
        want = expected_tokens.pop_front();
        if (got.char_out !== want.char_out)
            report_mismatch($sformatf("char_out %h, expected %h", got.char_out, want.char_out));
        if (got.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d on char %h",
                                      got.kind, want.kind, want.char_out));
        if (got.token_first !== want.token_first)
            report_mismatch($sformatf("token_first %b, expected %b on char %h",
                                      got.token_first, want.token_first, want.char_out));
        if (got.token_last !== want.token_last)
            report_mismatch($sformatf("token_last %b, expected %b on char %h",
                                      got.token_last, want.token_last, want.char_out));
        if (got.is_keyword !== want.is_keyword)
            report_mismatch($sformatf("is_keyword %b, expected %b on char %h",
                                      got.is_keyword, want.is_keyword, want.char_out));
    endtask

    // request driver
    int send_hold = 0;
    int send_quiet = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            item <= '0;
        end
        else
        begin
            if (push && !full)
                take_char(item.char_in, item.source_end);
            if (!push || !full)
            begin
                if (send_hold != 0)
                begin
                    send_hold--;
                    push <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    item      <= pending_items.pop_front();
                    push      <= 1'b1;
                    send_hold = pick_gap(send_quiet);
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // token monitor
    int pop_hold = 0;
    int pop_quiet = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                check_token(token);
                pop_hold = pick_gap(pop_quiet);
            end
            if (pop_hold != 0)
            begin
                pop_hold--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    // source text building
    function automatic void add_byte(logic [7:0] c);
        src_buf = {src_buf, c};
    endfunction

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    task automatic end_source();
        sct_in_t r;
        for (int i = 0; i < src_buf.size(); i++)
        begin
            r.char_in    = src_buf[i];
            r.source_end = (i == src_buf.size() - 1);
            pending_items = {pending_items, r};
        end
        src_buf.delete();
    endtask

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(0, 53);
        if (r < 26)
            return 8'("a" + r);
        if (r < 52)
            return 8'("A" + r - 26);
        return (r == 52) ? 8'("_") : 8'("$");
    endfunction

    function automatic logic [7:0] rand_text_byte();
        return 8'($urandom_range(32, 126));
    endfunction

    // one well-formed token, or now and then a random byte
    task automatic add_token();
        int r;
        int len;
        string blanks;
        blanks = " \t\r\n";
        r = $urandom_range(0, 99);
        if (r < 22)
        begin
            len = $urandom_range(0, 9);
            if (len < 2)
                add_text(kw_words[$urandom_range(0, 2)]);
            else if (len < 3)
                add_text(near_words[$urandom_range(0, 7)]);
            else
            begin
                len = (len == 9) ? $urandom_range(8, 20) : $urandom_range(1, 5);
                repeat (len) add_byte(rand_letter());
            end
        end
        else if (r < 36)
        begin
            repeat ($urandom_range(1, 5))
                add_byte(($urandom_range(0, 3) == 0) ? 8'(".") :
                         8'("0" + $urandom_range(0, 9)));
        end
        else if (r < 46)
        begin
            add_byte("\"");
            repeat ($urandom_range(0, 5))
            begin
                len = $urandom_range(0, 19);
                if (len < 5)
                    add_byte("\\");
                else if (len < 8)
                    add_byte("\"");
                else
                    add_byte(rand_text_byte());
            end
            if ($urandom_range(0, 3) != 0)
                add_byte("\"");
        end
        else if (r < 66)
        begin
            if ($urandom_range(0, 9) < 7)
                add_byte(operator_chars[$urandom_range(0, operator_chars.len() - 1)]);
            else
                add_text(pair_words[$urandom_range(0, 4)]);
        end
        else if (r < 80)
        begin
            add_byte(blanks[$urandom_range(0, 3)]);
        end
        else if (r < 95)
        begin
            add_text("//");
            repeat ($urandom_range(0, 5)) add_byte(rand_text_byte());
            if ($urandom_range(0, 4) != 0)
                add_byte(($urandom_range(0, 1) != 0) ? 8'("\n") : 8'("\r"));
        end
        else
        begin
            add_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // stimulus, reset and end of run
    initial
    begin
        clear_lexer();

        // keywords and an operator pair
        add_text("if<=exhaust");
        end_source();
        // escaped quote, comment up to a line feed, number with a dot, power pair
        add_text("do!=\"\\\"\"//\n.5**(");
        end_source();
        // an operator, an unknown byte, then a byte that must be ignored
        add_text(";");
        add_byte(8'h00);
        add_byte(8'hFF);
        end_source();
        // string left open at the end
        add_text("\"q");
        end_source();
        // comment closed by the end
        add_text("//z");
        end_source();

        // random sources: mostly tokens, a few made of raw bytes
        while (pending_items.size() < 370)
        begin
            if ($urandom_range(0, 19) == 0)
                repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
            else
                repeat ($urandom_range(1, 8)) add_token();
            end_source();
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (pending_items.size() != 0 || push || expected_tokens.size() != 0);
        repeat (20) @(posedge clk);

        if (error_count == 0 && expected_tokens.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/sct_pkg.sv
rtl/core/sct_front.sv
rtl/core/sct_result_queue.sv
rtl/core/source_char_tokenizer.sv
bench/source_char_tokenizer_tb.sv
